[rtl/trs_pkg.sv]
// Shared constants, types and functions for the model matrix builder.
`timescale 1ns / 1ps
package trs_pkg;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned TAB_LEN      = 30;
    localparam int unsigned ANG_W        = 34;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0] DEG2RAD_36 = 31'd1199381129;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [ANG_W-1:0]  t_q30;

    // Item handed from the front part to the back part through the queue.
    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word scale_x;
        t_word scale_y;
        t_word scale_z;
        t_q30  sx;
        t_q30  cx;
        t_q30  sy;
        t_q30  cy;
        t_q30  sz;
        t_q30  cz;
    } t_item;

    function automatic t_q30 atan_q30(input logic [4:0] idx);
        unique case (idx)
            5'd0:  atan_q30 = 34'sd843314857;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043837;
            5'd3:  atan_q30 = 34'sd133525159;
            5'd4:  atan_q30 = 34'sd67021687;
            5'd5:  atan_q30 = 34'sd33543516;
            5'd6:  atan_q30 = 34'sd16775851;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194283;
            5'd9:  atan_q30 = 34'sd2097149;
            default: atan_q30 = t_q30'(64'sd1 <<< (5'd30 - idx));
        endcase
    endfunction

    // Round half up a Q30 x Q30 product back to Q30.
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*ANG_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        mul_q30 = t_q30'(p >>> 30);
    endfunction
endpackage

[rtl/trs_sincos.sv]
// Angle reduction and pipelined CORDIC giving sine and cosine in Q30.
`timescale 1ns / 1ps
module trs_sincos #(
    parameter int unsigned CORDIC_STEPS = trs_pkg::CORDIC_STEPS,
    parameter int unsigned FRAC_BITS    = trs_pkg::FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  trs_pkg::t_word        i_angle,
    output logic                  o_valid,
    output trs_pkg::t_q30         o_sin,
    output trs_pkg::t_q30         o_cos
);
    import trs_pkg::*;

    localparam int unsigned STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam logic signed [33:0] QUARTER = 34'sd90 <<< FRAC_BITS;
    localparam int unsigned IW = DATA_W - FRAC_BITS;
    localparam int unsigned RK = IW + 9;
    localparam int unsigned PW = 2 * IW + 1;
    localparam logic [PW-1:0] RECIP = PW'(((64'd1 << RK) + 64'd359) / 64'd360);
    localparam logic [RK-1:0] OFF   = RK'((64'd1 << (IW - 1)) % 64'd360);

    // Stage A: modulo 360 on the integer degrees by reciprocal multiply.
    // Bias the signed integer part to unsigned, reduce, then remove the bias.
    logic signed [33:0] r_a;
    logic               r_va;
    logic [IW-1:0]      n_u;
    logic [PW-1:0]      n_qp;
    logic [RK-1:0]      n_quo, n_m, n_hm;
    logic signed [33:0] n_mod;
    assign n_u   = {~i_angle[DATA_W-1], i_angle[DATA_W-2:FRAC_BITS]};
    assign n_qp  = PW'(n_u) * RECIP;
    assign n_quo = RK'(n_qp >> RK);
    assign n_m   = RK'(n_u) - n_quo * RK'(360);
    assign n_hm  = (n_m >= OFF) ? n_m - OFF : n_m + (RK'(360) - OFF);
    assign n_mod = $signed(34'({n_hm, i_angle[FRAC_BITS-1:0]}));

    // Stage B: quadrant by compares, residual to radians
    logic [1:0]         n_q;
    logic signed [33:0] n_r;
    always_comb begin
        if (r_a >= 3 * QUARTER) begin
            n_q = 2'd3; n_r = r_a - 3 * QUARTER;
        end else if (r_a >= 2 * QUARTER) begin
            n_q = 2'd2; n_r = r_a - 2 * QUARTER;
        end else if (r_a >= QUARTER) begin
            n_q = 2'd1; n_r = r_a - QUARTER;
        end else begin
            n_q = 2'd0; n_r = r_a;
        end
    end
    logic [63:0] n_prod;
    assign n_prod = {30'd0, n_r} * {33'd0, DEG2RAD_36} + (64'd1 << (FRAC_BITS + 5));

    t_q30 r_x [STEPS+1];
    t_q30 r_y [STEPS+1];
    t_q30 r_z [STEPS+1];
    logic [1:0] r_q [STEPS+1];
    logic       r_v [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_v[0] <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_v[0] <= r_va;
        end
        r_a <= n_mod;
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= t_q30'(n_prod >> (FRAC_BITS + 6));
        r_q[0] <= n_q;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        t_q30 dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else          r_v[i+1] <= r_v[i];
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_q30(5'(i));
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_q30(5'(i));
            end
            r_q[i+1] <= r_q[i];
        end
    end

    always_comb begin
        case (r_q[STEPS])
            2'd0: begin o_sin = r_y[STEPS];  o_cos = r_x[STEPS];  end
            2'd1: begin o_sin = r_x[STEPS];  o_cos = -r_y[STEPS]; end
            2'd2: begin o_sin = -r_y[STEPS]; o_cos = -r_x[STEPS]; end
            default: begin o_sin = -r_x[STEPS]; o_cos = r_y[STEPS]; end
        endcase
    end
    assign o_valid = r_v[STEPS];
endmodule

[rtl/trs_front.sv]
// Front part: takes the object beat and runs the three sine/cosine pipes.
`timescale 1ns / 1ps
module trs_front #(
    parameter int unsigned CORDIC_STEPS = trs_pkg::CORDIC_STEPS,
    parameter int unsigned FRAC_BITS    = trs_pkg::FRAC_BITS,
    parameter int unsigned STEPS        = trs_pkg::CORDIC_STEPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  trs_pkg::t_word i_pos_x,
    input  trs_pkg::t_word i_pos_y,
    input  trs_pkg::t_word i_pos_z,
    input  trs_pkg::t_word i_angle_x,
    input  trs_pkg::t_word i_angle_y,
    input  trs_pkg::t_word i_angle_z,
    input  trs_pkg::t_word i_scale_x,
    input  trs_pkg::t_word i_scale_y,
    input  trs_pkg::t_word i_scale_z,
    output logic           o_valid,
    output trs_pkg::t_item o_item
);
    import trs_pkg::*;

    localparam int unsigned DEPTH = STEPS + 2;

    t_word r_px [DEPTH], r_py [DEPTH], r_pz [DEPTH];
    t_word r_kx [DEPTH], r_ky [DEPTH], r_kz [DEPTH];
    logic  vx, vy, vz;

    always_ff @(posedge i_clk) begin
        r_px[0] <= i_pos_x; r_py[0] <= i_pos_y; r_pz[0] <= i_pos_z;
        r_kx[0] <= i_scale_x; r_ky[0] <= i_scale_y; r_kz[0] <= i_scale_z;
        for (int i = 1; i < DEPTH; i++) begin
            r_px[i] <= r_px[i-1]; r_py[i] <= r_py[i-1]; r_pz[i] <= r_pz[i-1];
            r_kx[i] <= r_kx[i-1]; r_ky[i] <= r_ky[i-1]; r_kz[i] <= r_kz[i-1];
        end
    end

    trs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_sx (
        .i_clk, .i_rst_n, .i_valid, .i_angle(i_angle_x),
        .o_valid(vx), .o_sin(o_item.sx), .o_cos(o_item.cx));
    trs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_sy (
        .i_clk, .i_rst_n, .i_valid, .i_angle(i_angle_y),
        .o_valid(vy), .o_sin(o_item.sy), .o_cos(o_item.cy));
    trs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_sz (
        .i_clk, .i_rst_n, .i_valid, .i_angle(i_angle_z),
        .o_valid(vz), .o_sin(o_item.sz), .o_cos(o_item.cz));

    assign o_valid = vx & vy & vz;
    assign o_item.pos_x = r_px[DEPTH-1];
    assign o_item.pos_y = r_py[DEPTH-1];
    assign o_item.pos_z = r_pz[DEPTH-1];
    assign o_item.scale_x = r_kx[DEPTH-1];
    assign o_item.scale_y = r_ky[DEPTH-1];
    assign o_item.scale_z = r_kz[DEPTH-1];
endmodule

[rtl/trs_back.sv]
// Back part: builds the rotation products, then sends one row per cycle while emitting rows.
`timescale 1ns / 1ps
module trs_back #(
    parameter int unsigned FRAC_BITS = trs_pkg::FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  trs_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_strobe,
    output logic [1:0]     o_row_number,
    output trs_pkg::t_word o_entry_0,
    output trs_pkg::t_word o_entry_1,
    output trs_pkg::t_word o_entry_2,
    output trs_pkg::t_word o_entry_3,
    output logic           o_final_row
);
    import trs_pkg::*;

    t_item r_it;
    logic  r_busy;
    logic [1:0] r_row;
    t_q30 r_sxsy, r_cxsy;
    t_q30 r_rot [9];
    logic [1:0] r_ph;   // 0 products 1, 1 products 2, 2..: emitting rows

    // Load when idle; phase one: first-level products; phase two: full rotation; then rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph <= 2'd0;
            r_row <= 2'd0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= 1'b1;
                r_ph <= 2'd0;
                r_it <= i_item;
            end
        end else if (r_ph == 2'd0) begin
            r_sxsy <= mul_q30(r_it.sx, r_it.sy);
            r_cxsy <= mul_q30(r_it.cx, r_it.sy);
            r_rot[0] <= mul_q30(r_it.cy, r_it.cz);
            r_rot[1] <= -mul_q30(r_it.cy, r_it.sz);
            r_rot[2] <= r_it.sy;
            r_rot[5] <= -mul_q30(r_it.sx, r_it.cy);
            r_rot[8] <= mul_q30(r_it.cx, r_it.cy);
            r_ph <= 2'd1;
        end else if (r_ph == 2'd1) begin
            r_rot[3] <= mul_q30(r_sxsy, r_it.cz) + mul_q30(r_it.cx, r_it.sz);
            r_rot[4] <= mul_q30(r_it.cx, r_it.cz) - mul_q30(r_sxsy, r_it.sz);
            r_rot[6] <= mul_q30(r_it.sx, r_it.sz) - mul_q30(r_cxsy, r_it.cz);
            r_rot[7] <= mul_q30(r_cxsy, r_it.sz) + mul_q30(r_it.sx, r_it.cz);
            r_ph <= 2'd2;
            r_row <= 2'd0;
        end else begin
            r_row <= r_row + 2'd1;
            if (r_row == 2'd3) r_busy <= 1'b0;
        end
    end

    function automatic t_word scl(input t_q30 r, input t_word s);
        logic signed [65:0] p;
        logic signed [65:0] v;
        p = r * s + (66'sd1 <<< 29);
        v = p >>> 30;
        if (v > 66'sd2147483647) scl = 32'h7fffffff;
        else if (v < -66'sd2147483648) scl = 32'h80000000;
        else scl = t_word'(v);
    endfunction

    logic emit;
    assign emit = r_busy && r_ph == 2'd2;
    assign o_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else          o_strobe <= emit;
        o_row_number <= r_row;
        o_final_row  <= r_row == 2'd3;
        case (r_row)
            2'd0: begin
                o_entry_0 <= scl(r_rot[0], r_it.scale_x);
                o_entry_1 <= scl(r_rot[1], r_it.scale_y);
                o_entry_2 <= scl(r_rot[2], r_it.scale_z);
                o_entry_3 <= r_it.pos_x;
            end
            2'd1: begin
                o_entry_0 <= scl(r_rot[3], r_it.scale_x);
                o_entry_1 <= scl(r_rot[4], r_it.scale_y);
                o_entry_2 <= scl(r_rot[5], r_it.scale_z);
                o_entry_3 <= r_it.pos_y;
            end
            2'd2: begin
                o_entry_0 <= scl(r_rot[6], r_it.scale_x);
                o_entry_1 <= scl(r_rot[7], r_it.scale_y);
                o_entry_2 <= scl(r_rot[8], r_it.scale_z);
                o_entry_3 <= r_it.pos_z;
            end
            default: begin
                o_entry_0 <= '0;
                o_entry_1 <= '0;
                o_entry_2 <= '0;
                o_entry_3 <= t_word'(64'd1 << FRAC_BITS);
            end
        endcase
    end
endmodule

[rtl/trs_model_matrix_builder.sv]
// Top level of the translate/rotate/scale model matrix builder.
// Usage: raise start with one object (position, Euler angles in degrees,
// scale, all Q16.16) while busy is low; that beat is taken at the edge.
// From the accepting edge to the first row, an object passes the sine/cosine
// pipes, the queue write, the pop, the load into the row builder, the two
// rotation product phases and the output register. Four rows then follow on
// consecutive cycles, each marked by o_strobe for one cycle, row 3 with
// o_final_row high. The row builder handles one object at a time (pop, load,
// two product phases, four rows) and pops the next only after the last row.
// Objects are taken back to back until 30 are in the pipes and queue ahead
// of the row builder; busy then holds off new objects.
// Reset (synchronous, active low) drops every object in flight.
// The receiver cannot stall: each row beat is valid for one cycle only.
`timescale 1ns / 1ps
module trs_model_matrix_builder #(
    parameter int unsigned CORDIC_STEPS = trs_pkg::CORDIC_STEPS,
    parameter int unsigned FRAC_BITS    = trs_pkg::FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  trs_pkg::t_word i_pos_x,
    input  trs_pkg::t_word i_pos_y,
    input  trs_pkg::t_word i_pos_z,
    input  trs_pkg::t_word i_angle_x,
    input  trs_pkg::t_word i_angle_y,
    input  trs_pkg::t_word i_angle_z,
    input  trs_pkg::t_word i_scale_x,
    input  trs_pkg::t_word i_scale_y,
    input  trs_pkg::t_word i_scale_z,
    output logic           o_strobe,
    output logic [1:0]     o_row_number,
    output trs_pkg::t_word o_entry_0,
    output trs_pkg::t_word o_entry_1,
    output trs_pkg::t_word o_entry_2,
    output trs_pkg::t_word o_entry_3,
    output logic           o_final_row
);
    import trs_pkg::*;

    localparam int unsigned STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int unsigned QD  = 32;
    localparam int unsigned QAW = $clog2(QD);
    // Items inside the front pipe plus queue must fit; cap in-flight count.
    localparam int unsigned LIMIT = QD - 2;

    logic  f_valid, b_ready, take, pop;
    t_item f_item, q_head;
    t_item r_mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt, r_fly;

    assign take = start && !busy;
    assign busy = r_fly >= (QAW+1)'(LIMIT);

    trs_front #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS), .STEPS(STEPS)) u_front (
        .i_clk, .i_rst_n, .i_valid(take),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_angle_x, .i_angle_y, .i_angle_z,
        .i_scale_x, .i_scale_y, .i_scale_z,
        .o_valid(f_valid), .o_item(f_item));

    assign pop = (r_cnt != '0) && b_ready;

    always_ff @(posedge i_clk) begin
        if (f_valid) r_mem[r_wp] <= f_item;
        q_head <= r_mem[r_rp];
    end

    logic r_hv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_fly <= '0; r_hv <= 1'b0;
        end else begin
            if (f_valid) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(f_valid) - (QAW+1)'(pop);
            r_fly <= r_fly + (QAW+1)'(take) - (QAW+1)'(pop);
            r_hv <= pop;
        end
    end

    // Registered read: head is presented the cycle after pop.
    logic bq_ready;
    trs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(r_hv), .i_item(q_head), .o_ready(bq_ready),
        .o_strobe, .o_row_number, .o_entry_0, .o_entry_1, .o_entry_2,
        .o_entry_3, .o_final_row);
    // Pop only when the back end is idle and no head beat is in transit.
    assign b_ready = bq_ready && !r_hv;
endmodule
